// File: rtl/ucodec_pkg.sv
`timescale 1ns / 1ps

package ucodec_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } t_phase;

    // Up to three output bytes produced by one input byte.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_job;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (is_digit(c)) begin
            v = c[3:0];
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            v = c[3:0] - 4'd1 + HEX_TEN;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            v = c[3:0] - 4'd1 + HEX_TEN;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < HEX_TEN) begin
            c = CH_0 + {4'd0, nib};
        end else begin
            c = CH_UA + {4'd0, nib - HEX_TEN};
        end
        return c;
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               is_digit(c) || (c == CH_DOT) || (c == CH_DASH) ||
               (c == CH_UNDER) || (c == CH_STAR);
    endfunction

    function automatic t_job job_append(input t_job j, input logic [7:0] b);
        t_job r;
        r = j;
        case (j.cnt)
            2'd0: begin
                r.bytes[0] = b;
            end
            2'd1: begin
                r.bytes[1] = b;
            end
            default: begin
                r.bytes[2] = b;
            end
        endcase
        r.cnt = j.cnt + 2'd1;
        return r;
    endfunction

endpackage

// File: rtl/ucodec_in_if.sv
`timescale 1ns / 1ps

interface ucodec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: rtl/ucodec_out_if.sv
`timescale 1ns / 1ps

interface ucodec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/ucodec_cfg_if.sv
`timescale 1ns / 1ps

interface ucodec_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

// File: rtl/url_percent_codec.sv
// An accepted byte's job is registered in the job queue, then loaded into the
// output stage. One output byte per cycle while the output is ready; a byte
// that passes or maps to one character yields one, an escaped byte three.
// Reset (synchronous, active low) selects encode, drops any pending escape
// and empties the job queue and the output stage.
`timescale 1ns / 1ps

module url_percent_codec
    import ucodec_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ucodec_in_if.sink    i_in,
    ucodec_cfg_if.sink   i_cfg,
    ucodec_out_if.source o_out
);

    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    t_job f_job;
    t_job q_job;

    ucodec_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (f_job)
    );

    ucodec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ucodec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// File: rtl/ucodec_front.sv
`timescale 1ns / 1ps

module ucodec_front
    import ucodec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ucodec_in_if.sink     i_in,
    ucodec_cfg_if.sink    i_cfg,
    input  logic          i_q_ready,
    output logic          o_push,
    output t_job          o_job
);

    logic       r_dir;
    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_job       job;
    logic       idle_path;
    logic       accept;
    logic [7:0] b;
    logic       last;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign accept      = i_in.valid && i_q_ready;
    assign b           = i_in.in_byte;
    assign last        = i_in.last_byte;

    always_comb begin
        job       = '0;
        job.last  = last;
        n_phase   = r_phase;
        n_held    = r_held;
        idle_path = 1'b0;
        if (!r_dir) begin
            if (passes_plain(b)) begin
                job = job_append(job, b);
            end else if (b == CH_SPACE) begin
                job = job_append(job, CH_PLUS);
            end else begin
                job = job_append(job, CH_PCT);
                job = job_append(job, hex_upper(b[7:4]));
                job = job_append(job, hex_upper(b[3:0]));
            end
        end else begin
            n_phase = PH_IDLE;
            case (r_phase)
                PH_PCT: begin
                    if (is_hex(b)) begin
                        if (last) begin
                            job = job_append(job, CH_PCT);
                            job = job_append(job, b);
                        end else begin
                            n_held  = b;
                            n_phase = PH_DIG;
                        end
                    end else begin
                        job       = job_append(job, CH_PCT);
                        idle_path = 1'b1;
                    end
                end
                PH_DIG: begin
                    if (is_hex(b)) begin
                        job = job_append(job, {hex_val(r_held), hex_val(b)});
                    end else begin
                        job       = job_append(job, CH_PCT);
                        job       = job_append(job, r_held);
                        idle_path = 1'b1;
                    end
                    n_held = 8'd0;
                end
                default: begin
                    idle_path = 1'b1;
                end
            endcase
            if (idle_path) begin
                if (b == CH_PLUS) begin
                    job = job_append(job, CH_SPACE);
                end else if (b == CH_PCT) begin
                    if (last) begin
                        job = job_append(job, CH_PCT);
                    end else begin
                        n_phase = PH_PCT;
                    end
                end else begin
                    job = job_append(job, b);
                end
            end
            if (last) begin
                n_phase = PH_IDLE;
                n_held  = 8'd0;
            end
        end
    end

    // A byte that only opens or extends an escape produces nothing to queue.
    assign o_push = accept && (job.cnt != 2'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= 1'b0;
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (i_cfg.valid) begin
            r_dir   <= i_cfg.direction;
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// File: rtl/ucodec_queue.sv
`timescale 1ns / 1ps

module ucodec_queue
    import ucodec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10: begin
                    r_count <= r_count + 2'd1;
                end
                2'b01: begin
                    r_count <= r_count - 2'd1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

// File: rtl/ucodec_back.sv
`timescale 1ns / 1ps

module ucodec_back
    import ucodec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_job          i_q_job,
    output logic          o_pop,
    ucodec_out_if.source  o_out
);

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       at_end;
    logic       xfer;
    logic       done;

    assign at_end = (r_idx == (r_job.cnt - 2'd1));
    assign xfer   = r_busy && o_out.ready;
    assign done   = xfer && at_end;
    // The next job is loaded in the cycle that the current one's last byte transfers.
    assign o_pop  = i_q_valid && (!r_busy || done);

    assign o_out.valid    = r_busy;
    assign o_out.out_last = r_job.last && at_end;

    always_comb begin
        case (r_idx)
            2'd0: begin
                o_out.out_byte = r_job.bytes[0];
            end
            2'd1: begin
                o_out.out_byte = r_job.bytes[1];
            end
            default: begin
                o_out.out_byte = r_job.bytes[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (xfer) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// File: rtl/ucodec_checker.sv
`timescale 1ns / 1ps

module ucodec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_cfg_ready
);

    // The output stage is empty straight after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid straight after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped without a transfer");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("direction register refused a write");

endmodule

bind url_percent_codec ucodec_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last),
    .i_cfg_ready (i_cfg.ready)
);
